>>> rtl/core/pib_pkg.sv
package pib_pkg;

    localparam int MAX_BINS     = 1024;
    localparam int IDX_W        = 10;
    localparam int CNT_W        = 11;
    localparam int Q_W          = 11;
    localparam int TIME_W       = 48;
    localparam int WORD_W       = 16;
    localparam int OUT_DATA_W   = 224;
    localparam logic [WORD_W-1:0] SAT_WORD_LIMIT = 16'd65533;

    localparam logic [1:0] REG_OUTLIER_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_BIN_START         = 2'd1;
    localparam logic [1:0] REG_BIN_WIDTH         = 2'd2;
    localparam logic [1:0] REG_BINS_IN_USE       = 2'd3;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef enum logic [9:0] {
        S_SWEEP  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_PROC   = 10'b0000000100,
        S_ADV    = 10'b0000001000,
        S_PREP   = 10'b0000010000,
        S_RANGE  = 10'b0000100000,
        S_DIV    = 10'b0001000000,
        S_LOOKUP = 10'b0010000000,
        S_UPDATE = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    typedef struct packed {
        logic accept;
        logic sweep;
        logic proc;
        logic adv;
        logic prep;
        logic range_init;
        logic div_step;
        logic lookup;
        logic update;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_clear;
        logic accepted;
        logic sweep_last;
        logic div_last;
        logic hit;
    } sts_t;

endpackage

>>> rtl/core/pib_ctrl.sv
module pib_ctrl
    import pib_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   from_op_reg, from_op_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        from_op_next = from_op_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            S_SWEEP: begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last) begin
                    state_next = from_op_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (sts.is_clear) begin
                        from_op_next = 1'b1;
                        state_next   = S_SWEEP;
                    end else begin
                        state_next = S_PROC;
                    end
                end
            end
            S_PROC: begin
                cmd.proc   = 1'b1;
                state_next = S_ADV;
            end
            S_ADV: begin
                if (sts.accepted) begin
                    cmd.adv    = 1'b1;
                    state_next = S_PREP;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = S_RANGE;
            end
            S_RANGE: begin
                cmd.range_init = 1'b1;
                state_next     = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = sts.hit ? S_UPDATE : S_DONE;
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    from_op_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_SWEEP;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_SWEEP;
            from_op_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            from_op_reg <= from_op_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_tready))
        else $error("result loaded over a waiting result");

    a_reset_sweep: assert property (@(posedge aclk)
        $rose(aresetn) |-> state_reg == S_SWEEP)
        else $error("histogram not cleared after reset");

    a_update_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOOKUP && !sts.hit) |=> state_reg == S_DONE)
        else $error("bin updated without a hit");

endmodule

>>> rtl/core/pib_datapath.sv
module pib_datapath
    import pib_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic [WORD_W-1:0]     s_tdata,
    input  logic                  s_tuser,
    input  logic                  cfg_valid,
    input  logic [1:0]            cfg_index,
    input  logic [TIME_W-1:0]     cfg_data,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]            m_tuser
);

    logic [15:0]       thr_reg;
    logic [47:0]       start_reg;
    logic [31:0]       width_reg;
    logic [CNT_W-1:0]  bins_reg;

    logic [15:0]       word_reg;
    logic [31:0]       pending_reg, outl_reg, satc_reg, samp_reg, merged_reg;
    logic [47:0]       elapsed_reg;
    logic              acc_reg;
    logic [47:0]       rem_reg, div_reg;
    logic              ge_reg, over_reg;
    logic [Q_W-1:0]    q_reg;
    logic [3:0]        step_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [31:0]       cnt_reg, rdata_reg;
    logic [IDX_W-1:0]  sweep_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [1:0]        out_user_reg;

    logic [31:0] hist_mem [MAX_BINS];

    logic [32:0] pend_sum, merge_sum;
    logic [48:0] time_sum;
    logic [31:0] w_eff;
    logic [CNT_W-1:0] n_eff;
    logic [31:0] cnt_inc;

    always_comb begin
        pend_sum  = {1'b0, pending_reg} + {17'd0, word_reg};
        merge_sum = {1'b0, pending_reg} + {17'd0, word_reg};
        time_sum  = {1'b0, elapsed_reg} + {17'd0, merged_reg};
        w_eff     = (width_reg == 32'd0) ? 32'd1 : width_reg;
        n_eff     = (bins_reg > CNT_W'(MAX_BINS)) ? CNT_W'(MAX_BINS) : bins_reg;
        cnt_inc   = (&rdata_reg) ? rdata_reg : rdata_reg + 32'd1;
    end

    always_comb begin
        sts.is_clear   = (s_tuser == OP_CLEAR);
        sts.accepted   = acc_reg;
        sts.sweep_last = (sweep_reg == IDX_W'(MAX_BINS - 1));
        sts.div_last   = (step_reg == 4'd0);
        sts.hit        = ge_reg && !over_reg && (q_reg < n_eff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= '0;
            start_reg <= '0;
            width_reg <= 32'd1;
            bins_reg  <= CNT_W'(1024);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_OUTLIER_THRESHOLD: thr_reg   <= cfg_data[15:0];
                REG_BIN_START:         start_reg <= cfg_data;
                REG_BIN_WIDTH:         width_reg <= cfg_data[31:0];
                REG_BINS_IN_USE:       bins_reg  <= cfg_data[CNT_W-1:0];
                default:               thr_reg   <= thr_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (cmd.accept && s_tuser == OP_CLEAR)) begin
            pending_reg <= '0;
            elapsed_reg <= '0;
            outl_reg    <= '0;
            satc_reg    <= '0;
            samp_reg    <= '0;
            merged_reg  <= '0;
            acc_reg     <= 1'b0;
            hit_reg     <= 1'b0;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            sweep_reg   <= '0;
        end else begin
            if (cmd.accept) begin
                word_reg <= s_tdata;
            end
            if (cmd.sweep) begin
                sweep_reg <= sweep_reg + IDX_W'(1);
            end
            if (cmd.proc) begin
                hit_reg  <= 1'b0;
                idx_reg  <= '0;
                cnt_reg  <= '0;
                samp_reg <= (&samp_reg) ? samp_reg : samp_reg + 32'd1;
                if (word_reg > SAT_WORD_LIMIT) begin
                    satc_reg <= (&satc_reg) ? satc_reg : satc_reg + 32'd1;
                end
                if (word_reg < thr_reg) begin
                    acc_reg     <= 1'b0;
                    merged_reg  <= '0;
                    outl_reg    <= (&outl_reg) ? outl_reg : outl_reg + 32'd1;
                    pending_reg <= pend_sum[32] ? 32'hFFFF_FFFF : pend_sum[31:0];
                end else begin
                    acc_reg     <= 1'b1;
                    merged_reg  <= merge_sum[32] ? 32'hFFFF_FFFF : merge_sum[31:0];
                    pending_reg <= '0;
                end
            end
            if (cmd.adv) begin
                elapsed_reg <= time_sum[48] ? {TIME_W{1'b1}} : time_sum[47:0];
            end
            if (cmd.update) begin
                hit_reg <= 1'b1;
                idx_reg <= q_reg[IDX_W-1:0];
                cnt_reg <= cnt_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            ge_reg  <= (elapsed_reg >= start_reg);
            rem_reg <= (elapsed_reg == start_reg) ? '0 : elapsed_reg + ~start_reg;
        end
        if (cmd.range_init) begin
            over_reg <= ({1'b0, rem_reg} >= {6'd0, w_eff, 11'd0});
            div_reg  <= {6'd0, w_eff, 10'd0};
            q_reg    <= '0;
            step_reg <= 4'd10;
        end
        if (cmd.div_step) begin
            if (rem_reg >= div_reg) begin
                rem_reg <= rem_reg - div_reg;
                q_reg   <= {q_reg[Q_W-2:0], 1'b1};
            end else begin
                q_reg <= {q_reg[Q_W-2:0], 1'b0};
            end
            div_reg  <= {1'b0, div_reg[47:1]};
            step_reg <= step_reg - 4'd1;
        end
        if (cmd.load_out) begin
            out_user_reg <= {hit_reg, acc_reg};
            out_data_reg <= {6'd0, samp_reg, satc_reg, outl_reg, cnt_reg, idx_reg,
                             acc_reg ? elapsed_reg : 48'd0, merged_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sweep) begin
            hist_mem[sweep_reg] <= '0;
        end else if (cmd.update) begin
            hist_mem[q_reg[IDX_W-1:0]] <= cnt_inc;
        end
        if (cmd.lookup) begin
            rdata_reg <= hist_mem[q_reg[IDX_W-1:0]];
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

endmodule

>>> rtl/core/photon_interval_binner_core.sv
// Photon arrival-time histogram. Each request is one raw interval word (or a clear) and
// returns one result. An outlier sample passes S_PROC and S_ADV before S_DONE; an
// accepted photon also passes S_PREP, S_RANGE, S_DIV and S_LOOKUP, and S_UPDATE when it
// lands in a bin: the bin index comes from an 11-step restoring divider that shares one
// 48-bit subtractor, followed by a read-modify-write of the 1024-entry histogram memory.
// A clear request, and reset itself, zero the histogram one entry per cycle, so no
// request is taken until all 1024 entries are cleared after reset or after a clear;
// configuration writes are accepted at any time but must only be issued while the block
// is idle. A new request is taken while the previous result still waits on the output.
module photon_interval_binner_core
    import pib_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [WORD_W-1:0]     s_tdata,   // raw_interval
    input  logic                  s_tuser,   // opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // merged_interval, arrival_time, bin_index, bin_count, outlier_total,
    // saturation_total, sample_total, zero padding
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]            m_tuser,   // accepted, bin_hit
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [TIME_W-1:0]     cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    pib_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pib_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

>>> dv/photon_interval_binner_core_checker.sv
`timescale 1ns / 100ps

module photon_interval_binner_core_checker
    import pib_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [WORD_W-1:0]     s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [1:0]            m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [TIME_W-1:0]     cfg_data,
    output int                    error_count,
    output int                    results_pending
);

    typedef struct packed {
        logic              accepted;
        logic [31:0]       merged;
        logic [TIME_W-1:0] arrival;
        logic              hit;
        logic [IDX_W-1:0]  index;
        logic [31:0]       count;
        logic [31:0]       outliers;
        logic [31:0]       saturations;
        logic [31:0]       samples;
    } photon_result_t;

    photon_result_t photon_results_due[$];

    logic [15:0]       thr_q;
    logic [TIME_W-1:0] start_q;
    logic [31:0]       width_q;
    logic [10:0]       nbins_q;

    logic [31:0]       pending_sum;
    logic [TIME_W-1:0] elapsed;
    logic [31:0]       outlier_cnt;
    logic [31:0]       sat_cnt;
    logic [31:0]       sample_cnt;
    logic [31:0]       hist [MAX_BINS];

    assign results_pending = photon_results_due.size();

    task automatic clear_capture();
        pending_sum = '0;
        elapsed     = '0;
        outlier_cnt = '0;
        sat_cnt     = '0;
        sample_cnt  = '0;
        for (int i = 0; i < MAX_BINS; i++) hist[i] = '0;
    endtask

    function automatic logic [31:0] inc32(logic [31:0] v);
        return (v == 32'hFFFFFFFF) ? v : v + 32'd1;
    endfunction

    task automatic bin_photon(input logic opcode, input logic [15:0] word,
                              output photon_result_t r);
        logic [32:0] msum;
        logic [48:0] tsum;
        logic [63:0] d;
        logic [63:0] w;
        logic [63:0] k;
        logic [63:0] n;
        r = '0;
        if (opcode == OP_CLEAR) begin
            clear_capture();
        end else begin
            sample_cnt = inc32(sample_cnt);
            if (word > SAT_WORD_LIMIT) sat_cnt = inc32(sat_cnt);
            if (word < thr_q) begin
                outlier_cnt = inc32(outlier_cnt);
                msum = {1'b0, pending_sum} + {17'd0, word};
                pending_sum = msum[32] ? 32'hFFFFFFFF : msum[31:0];
            end else begin
                r.accepted = 1'b1;
                msum = {1'b0, pending_sum} + {17'd0, word};
                r.merged = msum[32] ? 32'hFFFFFFFF : msum[31:0];
                pending_sum = '0;
                tsum = {1'b0, elapsed} + {17'd0, r.merged};
                elapsed = tsum[48] ? {TIME_W{1'b1}} : tsum[TIME_W-1:0];
                r.arrival = elapsed;
                if (elapsed >= start_q) begin
                    d = {16'd0, elapsed - start_q};
                    w = (width_q == 0) ? 64'd1 : {32'd0, width_q};
                    n = (nbins_q > 11'(MAX_BINS)) ? 64'(MAX_BINS) : {53'd0, nbins_q};
                    k = (d == 0) ? 64'd0 : (d - 64'd1) / w;
                    if (k < n) begin
                        hist[k[IDX_W-1:0]] = inc32(hist[k[IDX_W-1:0]]);
                        r.hit   = 1'b1;
                        r.index = k[IDX_W-1:0];
                        r.count = hist[k[IDX_W-1:0]];
                    end
                end
            end
        end
        r.outliers    = outlier_cnt;
        r.saturations = sat_cnt;
        r.samples     = sample_cnt;
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= 10)
                $display("Mismatch in %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        photon_result_t e;
        photon_result_t a;
        if (!aresetn) begin
            error_count = 0;
            photon_results_due.delete();
            thr_q   = '0;
            start_q = '0;
            width_q = 32'd1;
            nbins_q = 11'd1024;
            clear_capture();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_OUTLIER_THRESHOLD: thr_q = cfg_data[15:0];
                    REG_BIN_START:         start_q = cfg_data;
                    REG_BIN_WIDTH:         width_q = cfg_data[31:0];
                    REG_BINS_IN_USE:       nbins_q = cfg_data[10:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                bin_photon(s_tuser, s_tdata, e);
                photon_results_due.push_back(e);
            end
            if (m_tvalid && m_tready) begin
                a.accepted    = m_tuser[0];
                a.hit         = m_tuser[1];
                a.merged      = m_tdata[31:0];
                a.arrival     = m_tdata[79:32];
                a.index       = m_tdata[89:80];
                a.count       = m_tdata[121:90];
                a.outliers    = m_tdata[153:122];
                a.saturations = m_tdata[185:154];
                a.samples     = m_tdata[217:186];
                if (photon_results_due.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("Unexpected result: %h", m_tdata);
                end else begin
                    e = photon_results_due.pop_front();
                    compare_field("accepted", {63'd0, e.accepted}, {63'd0, a.accepted});
                    compare_field("merged_interval", {32'd0, e.merged}, {32'd0, a.merged});
                    compare_field("arrival_time", {16'd0, e.arrival}, {16'd0, a.arrival});
                    compare_field("bin_hit", {63'd0, e.hit}, {63'd0, a.hit});
                    compare_field("bin_index", {54'd0, e.index}, {54'd0, a.index});
                    compare_field("bin_count", {32'd0, e.count}, {32'd0, a.count});
                    compare_field("outlier_total", {32'd0, e.outliers},
                                  {32'd0, a.outliers});
                    compare_field("saturation_total", {32'd0, e.saturations},
                                  {32'd0, a.saturations});
                    compare_field("sample_total", {32'd0, e.samples}, {32'd0, a.samples});
                    compare_field("padding", 64'd0, {58'd0, m_tdata[OUT_DATA_W-1:218]});
                end
            end
        end
    end

endmodule

>>> dv/photon_interval_binner_core_test.sv
`timescale 1ns / 100ps

module photon_interval_binner_core_test;
    import pib_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SETTLE      = 40;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [WORD_W-1:0]     s_tdata = '0;
    logic                  s_tuser = OP_SAMPLE;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = REG_OUTLIER_THRESHOLD;
    logic [TIME_W-1:0]     cfg_data = '0;
    int                    error_count;
    int                    results_pending;

    int  idle_mode = 0;
    logic long_hold_req = 1'b0;
    int  hold_left = 0;
    bit  hold_done = 0;
    int  cycles = 0;

    always #5 aclk = ~aclk;

    photon_interval_binner_core DUT (.*);

    photon_interval_binner_core_checker checker_i (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (long_hold_req && !hold_done) begin
            hold_done = 1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (idle_mode == 2) begin
            m_tready <= ($urandom % 100) >= 46;
        end else if (idle_mode == 3) begin
            m_tready <= ($urandom % 100) >= 31;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_request(input logic op, input logic [15:0] word);
        int gap;
        gap = 0;
        if (idle_mode == 1 && ($urandom % 100) < 46) gap = $urandom_range(1, 5);
        if (idle_mode == 3 && ($urandom % 100) < 31) gap = $urandom_range(1, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [TIME_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic settle_and_configure(input logic [15:0] thr,
                                        input logic [TIME_W-1:0] start,
                                        input logic [31:0] width,
                                        input logic [10:0] nbins);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        write_reg(REG_OUTLIER_THRESHOLD, {32'd0, thr});
        write_reg(REG_BIN_START, start);
        write_reg(REG_BIN_WIDTH, {16'd0, width});
        write_reg(REG_BINS_IN_USE, {37'd0, nbins});
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_word(input logic [15:0] thr, input int wmax);
        case ($urandom % 20)
            0: return 16'hFFFF;
            1: return 16'($urandom_range(65533, 65535));
            2: return 16'd0;
            3: return (thr == 0) ? 16'd0 : thr - 16'd1;
            4: return thr;
            5: return 16'($urandom);
            default: return 16'($urandom_range(0, wmax));
        endcase
    endfunction

    logic [15:0]       ph_thr   [6] = '{16'd0, 16'd100, 16'hFFFF, 16'd1000, 16'd5, 16'd2000};
    logic [TIME_W-1:0] ph_start [6] = '{48'd0, 48'd500, 48'd0, 48'hFFFFFFFFFFFF, 48'd0,
                                        48'd100000};
    logic [31:0]       ph_width [6] = '{32'd1, 32'd50, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                        32'd4096};
    logic [10:0]       ph_bins  [6] = '{11'd1024, 11'd20, 11'd0, 11'h7FF, 11'd1, 11'd1024};
    int                ph_wmax  [6] = '{8, 300, 65535, 65535, 65535, 20000};
    logic [15:0]       directed [20] = '{16'd4, 16'd4, 16'd12, 16'd0, 16'd9, 16'd10,
                                         16'd11, 16'd3, 16'd3, 16'd3, 16'd3, 16'd65533,
                                         16'd65534, 16'd65535, 16'd1, 16'd10, 16'd10,
                                         16'd10, 16'd10, 16'd10};

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        settle_and_configure(16'd10, 48'd20, 32'd3, 11'd4);
        foreach (directed[i]) send_request(OP_SAMPLE, directed[i]);
        send_request(OP_CLEAR, 16'hFFFF);
        send_request(OP_SAMPLE, 16'd20);
        send_request(OP_SAMPLE, 16'd11);

        for (int p = 0; p < 8; p++) begin
            int ph;
            ph = p % 6;
            settle_and_configure(ph_thr[ph], ph_start[ph], ph_width[ph], ph_bins[ph]);
            idle_mode = p % 4;
            send_request(OP_CLEAR, 16'($urandom));
            for (int n = 0; n < 170; n++) begin
                if (ph == 4 && n == 20) long_hold_req = 1'b1;
                if (($urandom % 100) < 2)
                    send_request(OP_CLEAR, 16'($urandom));
                else
                    send_request(OP_SAMPLE, pick_word(ph_thr[ph], ph_wmax[ph]));
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/pib_pkg.sv
rtl/core/pib_ctrl.sv
rtl/core/pib_datapath.sv
rtl/core/photon_interval_binner_core.sv
dv/photon_interval_binner_core_checker.sv
dv/photon_interval_binner_core_test.sv
